@@ hw/rtl/tmeb_pkg.sv @@
// ----------------------------------------------------------------------------
// tmeb_pkg
// Shared constants and types of the two-minimum-edge tour bound block.
// ----------------------------------------------------------------------------
package tmeb_pkg;

   // Matrix geometry and data widths.
   localparam int MAX_CITIES   = 16;
   localparam int CITY_BITS    = 4;
   localparam int DIST_BITS    = 16;
   localparam int ADDR_BITS    = 2 * CITY_BITS;
   localparam int DIST_DEPTH   = MAX_CITIES * MAX_CITIES;
   localparam int COUNT_BITS   = 5;
   localparam int MASK_BITS    = 16;
   localparam int BOUND_BITS   = 20;
   localparam int TOTAL_BITS   = BOUND_BITS + 1;
   localparam int ENDS_BITS    = DIST_BITS + 1;
   localparam int FOUND_BITS   = 2;

   localparam logic [BOUND_BITS-1:0] BOUND_MAX = {BOUND_BITS{1'b1}};

   // Request kinds carried on tuser.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CITY_COUNT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_CITY = 1'b1;

   // Control that travels with each distance read into the row minimum unit.
   typedef struct packed {
      logic clear;     // start of a new query: clear the accumulators
      logic valid;     // a distance read returns in this cycle
      logic use_dist;  // column city is open and differs from the row city
      logic row_end;   // last column of the row
      logic row_open;  // row city is open
      logic end_city;  // row city is the start or the current city
   } scan_ctl_type;

endpackage

@@ hw/rtl/tmeb_dist_ram.sv @@
// ----------------------------------------------------------------------------
// tmeb_dist_ram
// Distance matrix storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tmeb_dist_ram (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [tmeb_pkg::ADDR_BITS-1:0]     wr_addr,
   input  logic [tmeb_pkg::DIST_BITS-1:0]     wr_data,
   input  logic                               rd_en,
   input  logic [tmeb_pkg::ADDR_BITS-1:0]     rd_addr,
   output logic [tmeb_pkg::DIST_BITS-1:0]     rd_data
);

   logic [tmeb_pkg::DIST_BITS-1:0] mem [tmeb_pkg::DIST_DEPTH];
   logic [tmeb_pkg::DIST_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/tmeb_row_min.sv @@
// ----------------------------------------------------------------------------
// tmeb_row_min
// Tracks the two smallest distances of the current row and accumulates the
// per-city halves into the running tour bound.
// ----------------------------------------------------------------------------
module tmeb_row_min (
   input  logic                                clock,
   input  logic                                reset,
   input  tmeb_pkg::scan_ctl_type              ctl,
   input  logic [tmeb_pkg::DIST_BITS-1:0]      dist_value,
   output logic [tmeb_pkg::BOUND_BITS-1:0]     bound
);

   logic [tmeb_pkg::FOUND_BITS-1:0]  found_ff, found_in;
   logic [tmeb_pkg::DIST_BITS-1:0]   min1_ff, min1_in;
   logic [tmeb_pkg::DIST_BITS-1:0]   min2_ff, min2_in;
   logic [tmeb_pkg::TOTAL_BITS-1:0]  total_ff;
   logic [tmeb_pkg::ENDS_BITS-1:0]   ends_ff;
   logic [tmeb_pkg::DIST_BITS-1:0]   min_lo;
   logic [tmeb_pkg::DIST_BITS-1:0]   min_hi;
   logic [tmeb_pkg::DIST_BITS:0]     pair_sum;
   logic [tmeb_pkg::TOTAL_BITS:0]    grand_sum;

   // Insert the returning distance into the two smallest seen in this row.
   always_comb begin
      found_in = found_ff;
      min1_in  = min1_ff;
      min2_in  = min2_ff;
      if (ctl.valid && ctl.use_dist) begin
         case (found_ff)
            2'd0: begin
               min1_in  = dist_value;
               found_in = 2'd1;
            end
            2'd1: begin
               if (dist_value < min1_ff) begin
                  min2_in = min1_ff;
                  min1_in = dist_value;
               end else begin
                  min2_in = dist_value;
               end
               found_in = 2'd2;
            end
            default: begin
               if (dist_value < min1_ff) begin
                  min2_in = min1_ff;
                  min1_in = dist_value;
               end else if (dist_value < min2_ff) begin
                  min2_in = dist_value;
               end
            end
         endcase
      end
   end

   // A missing minimum counts as zero.
   assign min_lo   = (found_in != 2'd0) ? min1_in : '0;
   assign min_hi   = (found_in == 2'd2) ? min2_in : '0;
   assign pair_sum = {1'b0, min_lo} + {1'b0, min_hi};

   // Row state and query accumulators.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         found_ff <= '0;
         total_ff <= '0;
         ends_ff  <= '0;
      end else if (ctl.valid) begin
         if (ctl.row_end) begin
            found_ff <= '0;
            if (ctl.row_open) begin
               if (ctl.end_city) begin
                  ends_ff <= ends_ff + {1'b0, min_lo};
               end else begin
                  total_ff <= total_ff +
                     tmeb_pkg::TOTAL_BITS'(pair_sum[tmeb_pkg::DIST_BITS:1]);
               end
            end
         end else begin
            found_ff <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      min1_ff <= min1_in;
      min2_ff <= min2_in;
   end

   // The two end cities share one halving; the sum saturates.
   assign grand_sum = {1'b0, total_ff} +
                      (tmeb_pkg::TOTAL_BITS + 1)'(ends_ff[tmeb_pkg::ENDS_BITS-1:1]);
   assign bound = (grand_sum > (tmeb_pkg::TOTAL_BITS + 1)'(tmeb_pkg::BOUND_MAX))
                  ? tmeb_pkg::BOUND_MAX
                  : grand_sum[tmeb_pkg::BOUND_BITS-1:0];

endmodule

@@ hw/rtl/tsp_two_min_edge_bound_top.sv @@
// ----------------------------------------------------------------------------
// tsp_two_min_edge_bound_top
// Lower bound on the remaining length of a partial travelling-salesman tour,
// built on a distance matrix held in a single-port-write memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Content
//  req_*    in         tvalid/tready           tuser: load or query; tdata: fields
//  rsp_*    out        tvalid/tready           tdata: bound
//  csr_*    in         csr_we (no wait)        city_count, start_city
//
// A load writes the memory twice, once for each direction of the distance.
// A query scans the n x n matrix one distance per cycle through the memory
// read port; the trivial full-depth and one-step-short queries skip the scan.
// Reset is synchronous; the matrix holds no reset value. A finished result
// waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module tsp_two_min_edge_bound_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: row_city[3:0], col_city[7:4], edge_length[23:8],
   // visited_mask[39:24], current_city[43:40], visited_count[48:44], zero pad.
   input  logic [55:0] req_tdata,
   // tuser: op (0 load a distance, 1 query a bound).
   input  logic        req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: bound[19:0], zero pad.
   output logic [23:0] rsp_tdata,
   // Configuration port.
   input  logic                                   csr_we,
   input  logic [tmeb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tmeb_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD2,
      S_NEAR,
      S_NEAR_WAIT,
      S_SCAN,
      S_DRAIN,
      S_SUM,
      S_FINISH
   } state_type;

   localparam int CB = tmeb_pkg::CITY_BITS;

   // Request fields.
   logic [CB-1:0]                       req_row;
   logic [CB-1:0]                       req_col;
   logic [tmeb_pkg::DIST_BITS-1:0]      req_edge;
   logic [tmeb_pkg::MASK_BITS-1:0]      req_mask;
   logic [CB-1:0]                       req_cur;
   logic [tmeb_pkg::COUNT_BITS-1:0]     req_cnt;

   assign req_row  = req_tdata[3:0];
   assign req_col  = req_tdata[7:4];
   assign req_edge = req_tdata[23:8];
   assign req_mask = req_tdata[39:24];
   assign req_cur  = req_tdata[43:40];
   assign req_cnt  = req_tdata[48:44];

   state_type                           state_ff, state_in;
   logic [tmeb_pkg::COUNT_BITS-1:0]     city_count_ff, city_count_in;
   logic [CB-1:0]                       start_ff, start_in;
   logic [CB-1:0]                       row_ff, row_in;
   logic [CB-1:0]                       col_ff, col_in;
   logic [tmeb_pkg::DIST_BITS-1:0]      edge_ff, edge_in;
   logic [tmeb_pkg::MASK_BITS-1:0]      mask_ff, mask_in;
   logic [CB-1:0]                       cur_ff, cur_in;
   logic [CB-1:0]                       last_ff, last_in;
   logic [CB-1:0]                       i_ff, i_in;
   logic [CB-1:0]                       j_ff, j_in;
   logic [tmeb_pkg::BOUND_BITS-1:0]     result_ff, result_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tmeb_pkg::BOUND_BITS-1:0]     rsp_bound_ff, rsp_bound_in;
   tmeb_pkg::scan_ctl_type              tag_ff, tag_in;

   logic                                req_accept;
   logic [tmeb_pkg::COUNT_BITS-1:0]     n_sat;
   logic                                wr_en;
   logic [tmeb_pkg::ADDR_BITS-1:0]      wr_addr;
   logic [tmeb_pkg::DIST_BITS-1:0]      wr_data;
   logic                                rd_en;
   logic [tmeb_pkg::ADDR_BITS-1:0]      rd_addr;
   logic [tmeb_pkg::DIST_BITS-1:0]      rd_data;
   logic [tmeb_pkg::BOUND_BITS-1:0]     scan_bound;
   logic                                open_i;
   logic                                open_j;

   // A city is open when it is in use and either the start or unvisited.
   function automatic logic city_open(input logic [CB-1:0] c,
                                      input logic [tmeb_pkg::MASK_BITS-1:0] m,
                                      input logic [CB-1:0] last,
                                      input logic [CB-1:0] st);
      city_open = (c <= last) && ((c == st) || !m[c]);
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // City count saturated to the range 3 to MAX_CITIES.
   always_comb begin
      if (city_count_ff < tmeb_pkg::COUNT_BITS'(3)) begin
         n_sat = tmeb_pkg::COUNT_BITS'(3);
      end else if (city_count_ff > tmeb_pkg::COUNT_BITS'(tmeb_pkg::MAX_CITIES)) begin
         n_sat = tmeb_pkg::COUNT_BITS'(tmeb_pkg::MAX_CITIES);
      end else begin
         n_sat = city_count_ff;
      end
   end

   assign open_i = city_open(i_ff, mask_ff, last_ff, start_ff);
   assign open_j = city_open(j_ff, mask_ff, last_ff, start_ff);

   // Sequencer: loads, trivial queries and the matrix scan.
   always_comb begin
      state_in      = state_ff;
      city_count_in = city_count_ff;
      start_in      = start_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      edge_in       = edge_ff;
      mask_in       = mask_ff;
      cur_in        = cur_ff;
      last_in       = last_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_bound_in  = rsp_bound_ff;
      tag_in        = '0;
      wr_en         = 1'b0;
      wr_addr       = {req_row, req_col};
      wr_data       = req_edge;
      rd_en         = 1'b0;
      rd_addr       = {i_ff, j_ff};

      // Configuration writes.
      if (csr_we) begin
         unique case (csr_index)
            tmeb_pkg::REG_CITY_COUNT: city_count_in = csr_wdata;
            tmeb_pkg::REG_START_CITY: start_in = csr_wdata[CB-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == tmeb_pkg::OP_LOAD) begin
                  wr_en    = 1'b1;
                  row_in   = req_row;
                  col_in   = req_col;
                  edge_in  = req_edge;
                  state_in = S_LOAD2;
               end else begin
                  mask_in      = req_mask;
                  cur_in       = req_cur;
                  last_in      = CB'(n_sat - tmeb_pkg::COUNT_BITS'(1));
                  i_in         = '0;
                  j_in         = '0;
                  tag_in.clear = 1'b1;
                  if (req_cnt == n_sat) begin
                     result_in = '0;
                     state_in  = S_FINISH;
                  end else if (({1'b0, req_cnt} + 6'd1) >= {1'b0, n_sat}) begin
                     state_in = S_NEAR;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_LOAD2: begin
            wr_en    = 1'b1;
            wr_addr  = {col_ff, row_ff};
            wr_data  = edge_ff;
            state_in = S_IDLE;
         end
         S_NEAR: begin
            rd_en    = 1'b1;
            rd_addr  = {cur_ff, start_ff};
            state_in = S_NEAR_WAIT;
         end
         S_NEAR_WAIT: begin
            result_in = tmeb_pkg::BOUND_BITS'(rd_data);
            state_in  = S_FINISH;
         end
         S_SCAN: begin
            rd_en           = 1'b1;
            tag_in.valid    = 1'b1;
            tag_in.use_dist = open_i && open_j && (i_ff != j_ff);
            tag_in.row_end  = (j_ff == last_ff);
            tag_in.row_open = open_i;
            tag_in.end_city = (i_ff == start_ff) || (i_ff == cur_ff);
            if (j_ff == last_ff) begin
               j_in = '0;
               if (i_ff == last_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  i_in = i_ff + CB'(1);
               end
            end else begin
               j_in = j_ff + CB'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            result_in = scan_bound;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_bound_in = result_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, configuration and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         city_count_ff <= tmeb_pkg::COUNT_BITS'(tmeb_pkg::MAX_CITIES);
         start_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         tag_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         city_count_ff <= city_count_in;
         start_ff      <= start_in;
         rsp_valid_ff  <= rsp_valid_in;
         tag_ff        <= tag_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      edge_ff      <= edge_in;
      mask_ff      <= mask_in;
      cur_ff       <= cur_in;
      last_ff      <= last_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      result_ff    <= result_in;
      rsp_bound_ff <= rsp_bound_in;
   end

   tmeb_dist_ram u_dist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tmeb_row_min u_row_min (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tag_ff),
      .dist_value (rd_data),
      .bound      (scan_bound)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_bound_ff};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the two-minimum-edge tour bound block against a predictor kept here.
// The distance matrix is filled completely first, so no query ever reads an
// entry that was never loaded. Directed queries then cover the depth cases,
// the end cities, open sets too small for two minima, register saturation,
// and the largest distances. A long output stall and random traffic under
// several register settings follow. Both channels idle at random except in
// the last phase.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SETTLE_CYCLES   = 8;
   localparam int QUERY_CYCLES    = 300;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int HOLD_CYCLES     = 400;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 80;
   localparam int LOAD_PCT        = 35;

   // One request as seen by the block, before packing.
   typedef struct {
      logic                            op;
      logic [tmeb_pkg::CITY_BITS-1:0]  row_city;
      logic [tmeb_pkg::CITY_BITS-1:0]  col_city;
      logic [tmeb_pkg::DIST_BITS-1:0]  edge_length;
      logic [tmeb_pkg::MASK_BITS-1:0]  visited_mask;
      logic [tmeb_pkg::CITY_BITS-1:0]  current_city;
      logic [tmeb_pkg::COUNT_BITS-1:0] visited_count;
   } tour_request_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [55:0]                         req_tdata = '0;
   logic                                req_tuser = tmeb_pkg::OP_LOAD;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [23:0]                         rsp_tdata;
   logic                                csr_we = 1'b0;
   logic [tmeb_pkg::CSR_INDEX_BITS-1:0] csr_index = tmeb_pkg::REG_CITY_COUNT;
   logic [tmeb_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Predictor state: the distance matrix and the two registers.
   logic [tmeb_pkg::DIST_BITS-1:0]
      dist_matrix [tmeb_pkg::MAX_CITIES][tmeb_pkg::MAX_CITIES];
   logic [tmeb_pkg::COUNT_BITS-1:0] cfg_count = 5'd16;
   logic [tmeb_pkg::CITY_BITS-1:0]  cfg_start = '0;

   logic [tmeb_pkg::BOUND_BITS-1:0] pending_bounds [$];
   int                              error_count = 0;

   // Traffic shaping shared by the sender and the receiver.
   int unsigned idle_pct = 0;
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_active = 1'b0;

   tsp_two_min_edge_bound_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // The city count register saturates to the supported range.
   function automatic int cities_in_use();
      int n;
      n = int'(cfg_count);
      if (n < 3) n = 3;
      if (n > tmeb_pkg::MAX_CITIES) n = tmeb_pkg::MAX_CITIES;
      return n;
   endfunction

   // The start city is open when it is in use; cities past the count never are.
   function automatic bit city_open(int c, logic [tmeb_pkg::MASK_BITS-1:0] mask,
                                    int n);
      if (c >= n) return 1'b0;
      if (c == int'(cfg_start)) return 1'b1;
      return !mask[c];
   endfunction

   function automatic logic [tmeb_pkg::BOUND_BITS-1:0] predict_bound(
      logic [tmeb_pkg::MASK_BITS-1:0] mask, logic [tmeb_pkg::CITY_BITS-1:0] cur,
      logic [tmeb_pkg::COUNT_BITS-1:0] cnt);
      int     n;
      int     found;
      longint total, ends, m1, m2, d;
      n = cities_in_use();
      total = 0;
      ends = 0;
      if (int'(cnt) == n) return '0;
      if (int'(cnt) + 1 >= n)
         return {{(tmeb_pkg::BOUND_BITS-tmeb_pkg::DIST_BITS){1'b0}},
                 dist_matrix[cur][cfg_start]};
      for (int i = 0; i < n; i++) begin
         if (city_open(i, mask, n)) begin
            m1 = 0;
            m2 = 0;
            found = 0;
            // Keep the two smallest distances to other open cities.
            for (int j = 0; j < n; j++) begin
               if (j != i && city_open(j, mask, n)) begin
                  d = longint'(dist_matrix[i][j]);
                  if (found == 0) begin
                     m1 = d;
                     found = 1;
                  end else if (found == 1) begin
                     if (d < m1) begin
                        m2 = m1;
                        m1 = d;
                     end else begin
                        m2 = d;
                     end
                     found = 2;
                  end else if (d < m1) begin
                     m2 = m1;
                     m1 = d;
                  end else if (d < m2) begin
                     m2 = d;
                  end
               end
            end
            // Path ends give one edge each; inner cities give half of two.
            if (i == int'(cfg_start) || i == int'(cur)) ends += m1;
            else total += (m1 + m2) / 2;
         end
      end
      total += ends / 2;
      if (total > longint'(tmeb_pkg::BOUND_MAX)) return tmeb_pkg::BOUND_MAX;
      return total[tmeb_pkg::BOUND_BITS-1:0];
   endfunction

   // Update the matrix for a load, or queue the bound a query must give.
   function automatic void apply_request(tour_request_type rq);
      if (rq.op == tmeb_pkg::OP_LOAD) begin
         dist_matrix[rq.row_city][rq.col_city] = rq.edge_length;
         dist_matrix[rq.col_city][rq.row_city] = rq.edge_length;
      end else begin
         pending_bounds.push_back(
            predict_bound(rq.visited_mask, rq.current_city, rq.visited_count));
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic [tmeb_pkg::DIST_BITS-1:0] random_distance();
      logic [tmeb_pkg::DIST_BITS-1:0] d;
      d = tmeb_pkg::DIST_BITS'($urandom);
      case ($urandom_range(9, 0))
         0: d = '0;
         1: d = '1;
         2, 3, 4: d = d & 16'h000F;  // small values give many ties
         default: ;
      endcase
      return d;
   endfunction

   // Every field starts random, so unused fields carry noise.
   function automatic tour_request_type noise_request();
      tour_request_type rq;
      rq.op = $urandom_range(1, 0) ? tmeb_pkg::OP_QUERY : tmeb_pkg::OP_LOAD;
      rq.row_city = tmeb_pkg::CITY_BITS'($urandom);
      rq.col_city = tmeb_pkg::CITY_BITS'($urandom);
      rq.edge_length = tmeb_pkg::DIST_BITS'($urandom);
      rq.visited_mask = tmeb_pkg::MASK_BITS'($urandom);
      rq.current_city = tmeb_pkg::CITY_BITS'($urandom);
      rq.visited_count = tmeb_pkg::COUNT_BITS'($urandom_range(16, 0));
      return rq;
   endfunction

   function automatic tour_request_type random_request(int load_pct);
      tour_request_type               rq;
      int                             n;
      logic [tmeb_pkg::MASK_BITS-1:0] in_use;
      rq = noise_request();
      n = cities_in_use();
      in_use = (n == tmeb_pkg::MAX_CITIES) ? '1
               : ((tmeb_pkg::MASK_BITS'(1) << n) - 1'b1);
      if ($urandom_range(99, 0) < load_pct) begin
         rq.op = tmeb_pkg::OP_LOAD;
         rq.edge_length = random_distance();
      end else begin
         rq.op = tmeb_pkg::OP_QUERY;
         // Most queries look like a real partial path over the cities in use.
         if ($urandom_range(99, 0) < 75) begin
            rq.visited_mask = $urandom_range(1, 0)
                              ? tmeb_pkg::MASK_BITS'($urandom)
                              : tmeb_pkg::MASK_BITS'($urandom | $urandom);
            rq.visited_mask &= in_use;
            if (int'(cfg_start) < n) rq.visited_mask[cfg_start] = 1'b1;
            rq.current_city = tmeb_pkg::CITY_BITS'($urandom_range(n - 1, 0));
            rq.visited_mask[rq.current_city] = 1'b0;
            rq.visited_count = tmeb_pkg::COUNT_BITS'($countones(rq.visited_mask));
            case ($urandom_range(9, 0))
               0: rq.visited_count = tmeb_pkg::COUNT_BITS'(n);
               1: rq.visited_count = tmeb_pkg::COUNT_BITS'(n - 1);
               default: ;
            endcase
         end
      end
      return rq;
   endfunction

   // Offer one request and wait until it is taken.
   task automatic send_request(input tour_request_type rq);
      if (!calm && $urandom_range(99, 0) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.op;
      req_tdata  <= {7'b0, rq.visited_count, rq.current_city, rq.visited_mask,
                     rq.edge_length, rq.col_city, rq.row_city};
      do @(posedge clock); while (!req_tready);
      apply_request(rq);
   endtask

   task automatic load_distance(input int row, input int col,
                                input logic [tmeb_pkg::DIST_BITS-1:0] length);
      tour_request_type rq;
      rq = noise_request();
      rq.op = tmeb_pkg::OP_LOAD;
      rq.row_city = tmeb_pkg::CITY_BITS'(row);
      rq.col_city = tmeb_pkg::CITY_BITS'(col);
      rq.edge_length = length;
      send_request(rq);
   endtask

   task automatic query_bound(input logic [tmeb_pkg::MASK_BITS-1:0] mask,
                              input int cur, input int cnt);
      tour_request_type rq;
      rq = noise_request();
      rq.op = tmeb_pkg::OP_QUERY;
      rq.visited_mask = mask;
      rq.current_city = tmeb_pkg::CITY_BITS'(cur);
      rq.visited_count = tmeb_pkg::COUNT_BITS'(cnt);
      send_request(rq);
   endtask

   // Stop offering, wait for every expected bound, then let loads settle.
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_bounds.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_bounds.size() != 0) begin
         foreach (pending_bounds[k])
            $display("%0t: expected bound %0d, actual none", $time, pending_bounds[k]);
         error_count += pending_bounds.size();
         pending_bounds.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers; only called while the block is idle.
   task automatic configure(input logic [tmeb_pkg::CSR_DATA_BITS-1:0] count_value,
                            input logic [tmeb_pkg::CSR_DATA_BITS-1:0] start_value);
      csr_we    <= 1'b1;
      csr_index <= tmeb_pkg::REG_CITY_COUNT;
      csr_wdata <= count_value;
      @(posedge clock);
      csr_index <= tmeb_pkg::REG_START_CITY;
      csr_wdata <= start_value;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_count = count_value;
      cfg_start = start_value[tmeb_pkg::CITY_BITS-1:0];
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Load every entry, diagonal included, with both row and column orders.
   task automatic test_matrix_load();
      idle_pct = 20;
      for (int i = 0; i < tmeb_pkg::MAX_CITIES; i++) begin
         for (int j = i; j < tmeb_pkg::MAX_CITIES; j++) begin
            if ($urandom_range(1, 0)) load_distance(i, j, random_distance());
            else load_distance(j, i, random_distance());
         end
      end
      load_distance(0, 15, '0);
      load_distance(15, 0, '1);
      wait_drained();
   endtask

   // Depth and end-city cases under the register values left by reset.
   task automatic test_reset_config();
      idle_pct = 30;
      query_bound(16'h0000, 5, 1);
      query_bound(16'hFFFF, 3, 3);    // only the start city is open
      query_bound(16'hFF7F, 7, 2);    // start and current, one edge each
      query_bound(16'h00F0, 0, 4);    // current city is the start city
      query_bound(16'h0101, 8, 2);    // current city already visited
      query_bound(16'h7FFE, 15, 1);
      query_bound(16'h0000, 9, 16);   // full depth
      query_bound(16'hFFFF, 9, 15);   // one step short
      query_bound(16'h0000, 0, 15);   // one step short back to itself
      wait_drained();
   endtask

   // Count register saturation and a start city outside the cities in use.
   task automatic test_register_extremes();
      idle_pct = 30;
      configure(5'd31, 5'd17);
      query_bound(16'h0000, 4, 16);
      query_bound(16'h0002, 6, 15);
      query_bound(16'h1234, 2, 3);
      wait_drained();
      configure(5'd0, 5'd15);
      query_bound(16'h0000, 1, 0);
      query_bound(16'h0000, 12, 0);   // current city past the count
      query_bound(16'h0001, 2, 2);
      query_bound(16'h0000, 1, 5);    // count above the city count
      query_bound(16'h0000, 1, 3);
      wait_drained();
   endtask

   // Largest distances over five cities give the largest inner sums.
   task automatic test_saturated_distances();
      idle_pct = 0;
      configure(5'd5, 5'd2);
      for (int i = 0; i < 5; i++)
         for (int j = i; j < 5; j++)
            load_distance(i, j, '1);
      query_bound(16'h0000, 4, 0);
      query_bound(16'hFFE0, 2, 1);
      wait_drained();
   endtask

   // The receiver stalls for a long time while requests keep coming.
   task automatic test_output_backpressure();
      idle_pct = 0;
      configure(5'd3, 5'd0);
      hold_request = 1'b1;
      repeat (8) query_bound(tmeb_pkg::MASK_BITS'($urandom), $urandom_range(2, 0),
                             $urandom_range(1, 0));
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int unsigned idle_levels [4];
      idle_levels = '{0, 10, 30, 50};
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         calm = (phase == RANDOM_PHASES - 1);
         idle_pct = idle_levels[$urandom_range(3, 0)];
         case (phase)
            0: configure(5'd3, 5'd0);
            1: configure(5'd16, 5'd15);
            2: configure(5'd4, 5'd3);
            default: configure(tmeb_pkg::CSR_DATA_BITS'($urandom_range(16, 3)),
                               tmeb_pkg::CSR_DATA_BITS'($urandom_range(15, 0)));
         endcase
         repeat (ITEMS_PER_PHASE) send_request(random_request(LOAD_PCT));
         wait_drained();
      end
   endtask

   // ------------------------------------------------------------------------
   // Processes
   // ------------------------------------------------------------------------

   initial begin : test_sequence
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_matrix_load();
      test_reset_config();
      test_register_extremes();
      test_saturated_distances();
      test_output_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (QUERY_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tsp_two_min_edge_bound_top test passed");
      end else begin
         $display("tsp_two_min_edge_bound_top test failed");
      end
      $finish;
   end

   // The receiver stalls in bursts, or for the whole of a long hold.
   initial begin : response_ready
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_active) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(99, 0) < idle_pct) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(19, 1) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Long hold of the receiver, counted here so the sender runs freely.
   initial begin : response_hold
      forever begin
         wait (hold_request);
         @(posedge clock);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active = 1'b0;
         hold_request = 1'b0;
      end
   end

   // Each accepted bound must match the oldest expected one.
   initial begin : bound_checker
      logic [tmeb_pkg::BOUND_BITS-1:0] want;
      logic [tmeb_pkg::BOUND_BITS-1:0] got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            got = rsp_tdata[tmeb_pkg::BOUND_BITS-1:0];
            if (pending_bounds.size() == 0) begin
               $display("%0t: expected no response, actual bound %0d", $time, got);
               error_count++;
            end else begin
               want = pending_bounds.pop_front();
               if (got !== want) begin
                  $display("%0t: bound mismatch, expected %0d, actual %0d",
                           $time, want, got);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin : run_limit
      #40_000_000;
      $display("tsp_two_min_edge_bound_top test failed");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/tmeb_pkg.sv
hw/rtl/tmeb_dist_ram.sv
hw/rtl/tmeb_row_min.sv
hw/rtl/tsp_two_min_edge_bound_top.sv
test/testbench.sv
